FILE: hw/rtl/wsce_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wsce_pkg
// Shared types, constants and header byte selection for the masked client
// frame encoder.
// ---------------------------------------------------------------------------
package wsce_pkg;

   // Item codes
   localparam logic OP_BEGIN = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   // Frame format constants
   localparam logic [7:0]  FIN_BIT       = 8'h80;
   localparam logic [7:0]  MASK_BIT      = 8'h80;
   localparam logic [16:0] SHORT_LEN_MAX = 17'd125;
   localparam logic [7:0]  EXT16_MARK    = 8'd126;
   localparam logic [16:0] LEN_MAX       = 17'd65535;

   // Index of the last header byte for each header form
   localparam logic [2:0] HDR_LAST_SHORT = 3'd5;
   localparam logic [2:0] HDR_LAST_LONG  = 3'd7;

   // Job queue between front and back end (depth is a power of two)
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_REJECT = 2'd1,
      STATUS_STRAY  = 2'd2
   } status_type;

   typedef enum logic {
      JOB_SINGLE = 1'b0,
      JOB_HEADER = 1'b1
   } job_kind_type;

   typedef struct packed {
      logic        op;
      logic [3:0]  frame_opcode;
      logic [16:0] payload_length;
      logic [31:0] mask_key;
      logic [7:0]  data_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       frame_done;
      status_type status;
   } rsp_item_type;

   // One unit of work for the back end: a single result or a whole header
   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   byte_val;
      logic         done;
      status_type   status;
      logic [3:0]   opcode;
      logic [15:0]  length;
      logic [31:0]  key;
      logic         hdr_long;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

   // Select header byte idx of a frame header
   function automatic logic [7:0] hdr_byte(input job_type job, input logic [2:0] idx);
      logic [7:0] b;
      b = 8'h00;
      if (job.hdr_long) begin
         unique case (idx)
            3'd0: b = FIN_BIT | {4'h0, job.opcode};
            3'd1: b = MASK_BIT | EXT16_MARK;
            3'd2: b = job.length[15:8];
            3'd3: b = job.length[7:0];
            3'd4: b = job.key[31:24];
            3'd5: b = job.key[23:16];
            3'd6: b = job.key[15:8];
            3'd7: b = job.key[7:0];
            default: b = 8'h00;
         endcase
      end else begin
         unique case (idx)
            3'd0: b = FIN_BIT | {4'h0, job.opcode};
            3'd1: b = MASK_BIT | {1'b0, job.length[6:0]};
            3'd2: b = job.key[31:24];
            3'd3: b = job.key[23:16];
            3'd4: b = job.key[15:8];
            3'd5: b = job.key[7:0];
            default: b = 8'h00;
         endcase
      end
      return b;
   endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/wsce_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wsce_front
// Accepts items, tracks the open frame, masks payload bytes and posts one
// job per item to the queue. Holds the link_up register.
// ---------------------------------------------------------------------------
module wsce_front (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire                    csr_data,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wsce_pkg::req_item_type req_item,
   output logic                   push,
   output wsce_pkg::job_type      push_job,
   input  wsce_pkg::q_status_type q_status
);
   import wsce_pkg::*;

   logic        link_up_ff, link_up_in;
   logic        frame_active_ff, frame_active_in;
   logic [15:0] bytes_left_ff, bytes_left_in;
   logic [1:0]  mask_phase_ff, mask_phase_in;
   logic [31:0] mask_word_ff, mask_word_in;

   logic       rejected;
   logic [7:0] mask_byte;

   assign csr_ready = 1'b1;
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   // Pick the mask byte for the current phase, top byte first
   always_comb begin
      unique case (mask_phase_ff)
         2'd0: mask_byte = mask_word_ff[31:24];
         2'd1: mask_byte = mask_word_ff[23:16];
         2'd2: mask_byte = mask_word_ff[15:8];
         2'd3: mask_byte = mask_word_ff[7:0];
         default: mask_byte = 8'h00;
      endcase
   end

   // Classify the item and build its job and the next frame state
   always_comb begin
      rejected        = !link_up_ff || (req_item.payload_length > LEN_MAX);
      link_up_in      = (csr_valid && csr_ready) ? csr_data : link_up_ff;
      frame_active_in = frame_active_ff;
      bytes_left_in   = bytes_left_ff;
      mask_phase_in   = mask_phase_ff;
      mask_word_in    = mask_word_ff;

      push_job          = '0;
      push_job.kind     = JOB_SINGLE;
      push_job.status   = STATUS_OK;
      push_job.opcode   = req_item.frame_opcode;
      push_job.length   = req_item.payload_length[15:0];
      push_job.key      = req_item.mask_key;
      push_job.hdr_long = req_item.payload_length > SHORT_LEN_MAX;

      priority if (req_item.op == OP_BEGIN) begin
         // Drop any open frame, then open the new one if allowed
         frame_active_in = 1'b0;
         bytes_left_in   = '0;
         mask_phase_in   = '0;
         if (rejected) begin
            push_job.status = STATUS_REJECT;
         end else begin
            push_job.kind   = JOB_HEADER;
            push_job.done   = (req_item.payload_length == '0);
            mask_word_in    = req_item.mask_key;
            bytes_left_in   = req_item.payload_length[15:0];
            frame_active_in = (req_item.payload_length != '0);
         end
      end else if (!frame_active_ff) begin
         push_job.status = STATUS_STRAY;
      end else begin
         // Mask one payload byte and advance
         push_job.byte_val = req_item.data_byte ^ mask_byte;
         push_job.done     = (bytes_left_ff == 16'd1);
         bytes_left_in     = bytes_left_ff - 16'd1;
         mask_phase_in     = mask_phase_ff + 2'd1;
         frame_active_in   = (bytes_left_ff != 16'd1);
      end
   end

   // Frame state and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         link_up_ff      <= 1'b0;
         frame_active_ff <= 1'b0;
         bytes_left_ff   <= '0;
         mask_phase_ff   <= '0;
      end else begin
         link_up_ff <= link_up_in;
         if (push) begin
            frame_active_ff <= frame_active_in;
            bytes_left_ff   <= bytes_left_in;
            mask_phase_ff   <= mask_phase_in;
         end
      end
   end

   // Mask key holds no control state
   always_ff @(posedge clock) begin
      if (push) begin
         mask_word_ff <= mask_word_in;
      end
   end

   a_active_has_bytes : assert property (@(posedge clock) disable iff (reset)
      frame_active_ff |-> (bytes_left_ff != '0))
      else $error("open frame with no bytes left");

   a_idle_no_bytes : assert property (@(posedge clock) disable iff (reset)
      !frame_active_ff |-> (bytes_left_ff == '0))
      else $error("bytes left outside a frame");

endmodule
`default_nettype wire

FILE: hw/rtl/wsce_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wsce_queue
// Short job queue that decouples the front end from the byte emitter.
// ---------------------------------------------------------------------------
module wsce_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  wsce_pkg::job_type      push_job,
   input  wire                    pop,
   output wsce_pkg::job_type      head_job,
   output wsce_pkg::q_status_type q_status
);
   import wsce_pkg::*;

   job_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign head_job       = slot_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == '0);
   assign q_status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the job at the write slot
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_pop_not_empty : assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("queue popped while empty");

   a_ptr_count : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == QCNT_W'(QUEUE_DEPTH)) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with fill count");

endmodule
`default_nettype wire

FILE: hw/rtl/wsce_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// wsce_back
// Turns queued jobs into result items, one byte per cycle while the output
// is not stalled, through a registered output stage.
// ---------------------------------------------------------------------------
module wsce_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wsce_pkg::q_status_type q_status,
   input  wsce_pkg::job_type      head_job,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output wsce_pkg::rsp_item_type rsp_item
);
   import wsce_pkg::*;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic [2:0]   hdr_idx_ff, hdr_idx_in;

   logic [2:0] hdr_last;
   logic       last_byte;
   logic       out_free;
   logic       emit;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // Build the next result from the head job
   always_comb begin
      hdr_last  = head_job.hdr_long ? HDR_LAST_LONG : HDR_LAST_SHORT;
      last_byte = (head_job.kind == JOB_SINGLE) || (hdr_idx_ff == hdr_last);
      out_free  = !rsp_valid_ff || !rsp_stall;
      emit      = !q_status.empty && out_free;
      pop       = emit && last_byte;

      rsp_item_in.last_of_run = last_byte;
      rsp_item_in.frame_done  = last_byte && head_job.done;
      rsp_item_in.status      = head_job.status;
      unique case (head_job.kind)
         JOB_SINGLE: rsp_item_in.out_byte = head_job.byte_val;
         JOB_HEADER: rsp_item_in.out_byte = hdr_byte(head_job, hdr_idx_ff);
         default:    rsp_item_in.out_byte = 8'h00;
      endcase

      hdr_idx_in = hdr_idx_ff;
      if (emit && head_job.kind == JOB_HEADER) begin
         hdr_idx_in = last_byte ? 3'd0 : hdr_idx_ff + 3'd1;
      end

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         hdr_idx_ff   <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         hdr_idx_ff   <= hdr_idx_in;
      end
   end

   // Load the output register
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   a_hdr_idx_header : assert property (@(posedge clock) disable iff (reset)
      (hdr_idx_ff != 3'd0) |-> (!q_status.empty && head_job.kind == JOB_HEADER))
      else $error("header index running without a header job");

   a_hdr_idx_range : assert property (@(posedge clock) disable iff (reset)
      (hdr_idx_ff != 3'd0) |-> (hdr_idx_ff <= hdr_last))
      else $error("header index past last header byte");

endmodule
`default_nettype wire

FILE: hw/rtl/websocket_client_frame_encoder.sv
`default_nettype none
// ---------------------------------------------------------------------------
// websocket_client_frame_encoder
// Masked client frame encoder: header generation and payload masking.
// ---------------------------------------------------------------------------
// A payload byte item is taken every cycle unless the job queue is full. Its
// masked byte is written into the job queue and then into the output register
// before it is offered on the output. Payload therefore streams at one byte
// per clock while the output is not stalled. A begin item gives six header bytes
// (length up to 125) or eight (16-bit length). These leave the byte emitter
// one per cycle while the output is not stalled, so the item after a begin
// waits in the two-entry job queue and the input stalls once it is full.
// Rejected begins and stray payload bytes give one status item each.
// link_up is written through the csr port, which is always ready.
// ---------------------------------------------------------------------------
module websocket_client_frame_encoder (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire                    csr_data,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  wsce_pkg::req_item_type req_item,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output wsce_pkg::rsp_item_type rsp_item
);
   import wsce_pkg::*;

   logic         push;
   logic         pop;
   job_type      push_job;
   job_type      head_job;
   q_status_type q_status;

   wsce_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .push      (push),
      .push_job  (push_job),
      .q_status  (q_status)
   );

   wsce_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   wsce_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_job  (head_job),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule
`default_nettype wire

FILE: verif/wsce_frame_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wsce_frame_checker
// Watches the csr, request and response channels of the frame encoder,
// keeps its own copy of the encoder state, works out the bytes each
// accepted item must produce and compares every accepted response with the
// oldest outstanding byte, field by field.
// ---------------------------------------------------------------------------
module wsce_frame_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic                   csr_data,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  wsce_pkg::req_item_type req_item,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  wsce_pkg::rsp_item_type rsp_item,
   output int                     fail_count,
   output int                     pending,
   output int                     checked_count
);
   import wsce_pkg::*;

   // Shadow of the encoder state
   logic        link_up;
   logic        in_frame;
   logic [15:0] bytes_left;
   logic [1:0]  mask_phase;
   logic [31:0] mask_word;

   rsp_item_type expected_bytes [$];

   function automatic rsp_item_type make_byte(input logic [7:0] b, input logic last,
                                              input logic done, input status_type st);
      rsp_item_type r;
      r.out_byte    = b;
      r.last_of_run = last;
      r.frame_done  = done;
      r.status      = st;
      return r;
   endfunction

   // Work out the bytes one accepted item produces and advance the shadow state
   task automatic predict_frame_bytes(input req_item_type it);
      logic [7:0] hdr [$];
      logic [7:0] mask_byte;
      logic       empty;
      if (it.op == OP_BEGIN) begin
         // any unfinished frame is dropped, accepted or not
         in_frame   = 1'b0;
         bytes_left = '0;
         mask_phase = '0;
         if (!link_up || it.payload_length > LEN_MAX) begin
            expected_bytes.push_back(make_byte(8'h00, 1'b1, 1'b0, STATUS_REJECT));
         end else begin
            hdr.push_back(FIN_BIT | {4'h0, it.frame_opcode});
            if (it.payload_length <= SHORT_LEN_MAX) begin
               hdr.push_back(MASK_BIT | it.payload_length[7:0]);
            end else begin
               hdr.push_back(MASK_BIT | EXT16_MARK);
               hdr.push_back(it.payload_length[15:8]);
               hdr.push_back(it.payload_length[7:0]);
            end
            // key goes out most significant byte first
            hdr.push_back(it.mask_key[31:24]);
            hdr.push_back(it.mask_key[23:16]);
            hdr.push_back(it.mask_key[15:8]);
            hdr.push_back(it.mask_key[7:0]);
            mask_word  = it.mask_key;
            bytes_left = it.payload_length[15:0];
            empty      = (it.payload_length == '0);
            in_frame   = !empty;
            foreach (hdr[i]) begin
               expected_bytes.push_back(make_byte(hdr[i], i == hdr.size() - 1,
                                                  (i == hdr.size() - 1) && empty, STATUS_OK));
            end
         end
      end else if (!in_frame) begin
         expected_bytes.push_back(make_byte(8'h00, 1'b1, 1'b0, STATUS_STRAY));
      end else begin
         // mask with key byte (index mod 4), top byte first
         mask_byte  = mask_word[8 * (3 - mask_phase) +: 8];
         mask_phase = mask_phase + 2'd1;
         bytes_left = bytes_left - 16'd1;
         if (bytes_left == '0)
            in_frame = 1'b0;
         expected_bytes.push_back(make_byte(it.data_byte ^ mask_byte, 1'b1,
                                            bytes_left == '0, STATUS_OK));
      end
   endtask

   // Compare one accepted response with the oldest outstanding byte
   task automatic check_result(input rsp_item_type got);
      rsp_item_type want;
      checked_count++;
      if (expected_bytes.size() == 0) begin
         $error("unexpected response: out_byte %02h status %0d", got.out_byte, got.status);
         fail_count++;
      end else begin
         want = expected_bytes.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
            fail_count++;
         end
         if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
            fail_count++;
         end
         if (got.frame_done !== want.frame_done) begin
            $error("frame_done: expected %0b, got %0b", want.frame_done, got.frame_done);
            fail_count++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
         end
      end
   endtask

   // Check responses before predicting, so a byte never meets an
   // expectation pushed at the same edge; an item sees the link state
   // from before a csr write at the same edge
   always @(posedge clock) begin
      if (reset) begin
         link_up    = 1'b0;
         in_frame   = 1'b0;
         bytes_left = '0;
         mask_phase = '0;
         mask_word  = '0;
         expected_bytes.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            check_result(rsp_item);
         if (req_valid && !req_stall)
            predict_frame_bytes(req_item);
         if (csr_valid && csr_ready)
            link_up = csr_data;
      end
      pending = expected_bytes.size();
   end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Stimulus for the masked client frame encoder: a directed set covering
// header forms, length limits, rejects, stray bytes and link drop, then
// random frames over four idling phases with a long receiver hold-off.
// Checking is done by the frame checker instantiated beside the encoder.
// ---------------------------------------------------------------------------
module tb;
   import wsce_pkg::*;

   localparam int PHASE_ITEMS   = 105;
   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT   = 200000;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         csr_valid = 1'b0;
   logic         csr_data  = 1'b0;
   logic         csr_ready;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   int fail_count;
   int pending;
   int checked_count;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int holds_asked   = 0;
   int holds_served  = 0;
   int items_sent    = 0;
   int begins_sent   = 0;
   int bytes_sent    = 0;
   int phase_end     = 0;
   int cycle_count   = 0;

   websocket_client_frame_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   wsce_frame_checker frame_check (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_item      (req_item),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_item      (rsp_item),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Stop a hung run
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("Run stopped at the cycle limit of %0d", CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // Receiver: random stall, or a long hold-off when one is asked for
   initial begin
      forever begin
         @(posedge clock);
         if (holds_served != holds_asked) begin
            holds_served++;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // Item with every field random; callers overwrite what matters
   function automatic req_item_type random_item();
      req_item_type it;
      it.op             = 1'($urandom_range(1));
      it.frame_opcode   = 4'($urandom_range(15));
      it.payload_length = 17'($urandom_range(131071));
      it.mask_key       = $urandom;
      it.data_byte      = 8'($urandom_range(255));
      return it;
   endfunction

   // Offer one item after an optional idle gap; hold it until taken
   task automatic send_req(input req_item_type it);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= it;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (it.op == OP_BEGIN)
         begins_sent++;
      else
         bytes_sent++;
   endtask

   task automatic send_begin(input logic [3:0] opc, input logic [16:0] len,
                             input logic [31:0] key);
      req_item_type it;
      it                = random_item();
      it.op             = OP_BEGIN;
      it.frame_opcode   = opc;
      it.payload_length = len;
      it.mask_key       = key;
      send_req(it);
   endtask

   task automatic send_byte(input logic [7:0] d);
      req_item_type it;
      it           = random_item();
      it.op        = OP_DATA;
      it.data_byte = d;
      send_req(it);
   endtask

   // Drop valid and wait until every outstanding byte has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_link(input logic up);
      csr_valid <= 1'b1;
      csr_data  <= up;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_directed();
      // link still down from reset: begin refused, lone byte stray
      send_begin(4'h1, 17'd5, 32'hDEAD_BEEF);
      send_byte(8'h3C);
      wait_drained();
      write_link(1'b1);
      // empty payload, then a byte with no frame open
      send_begin(4'h1, 17'd0, 32'h0000_0000);
      send_byte(8'hFF);
      // longest short-form length
      send_begin(4'hF, 17'd125, 32'hFFFF_FFFF);
      send_byte(8'h00);
      send_byte(8'hFF);
      // shortest extended length, then a new begin drops the frame
      send_begin(4'h2, 17'd126, 32'h1234_5678);
      send_byte(8'h11);
      send_byte(8'h22);
      send_begin(4'h9, 17'd65535, 32'hA5A5_5A5A);
      send_byte(8'h80);
      // over-long lengths refused; the open frame is gone too
      send_begin(4'h8, 17'd65536, 32'h0F0F_F0F0);
      send_byte(8'h01);
      send_begin(4'hA, 17'd131071, 32'h8000_0001);
      // full frame through every mask byte, then one byte too many
      send_begin(4'h0, 17'd4, 32'h0102_0304);
      send_byte(8'hFE);
      send_byte(8'h7F);
      send_byte(8'hAA);
      send_byte(8'h55);
      send_byte(8'hC3);
      // link drops mid-frame: the open frame still completes
      send_begin(4'h1, 17'd3, 32'hCAFE_F00D);
      send_byte(8'h5A);
      wait_drained();
      write_link(1'b0);
      send_byte(8'h96);
      send_byte(8'h69);
      send_begin(4'h2, 17'd10, 32'h1111_2222);
      wait_drained();
      write_link(1'b1);
   endtask

   // One begin with random content and mostly the matching number of bytes, or a lone byte
   task automatic send_random_frame();
      int unsigned pick;
      int unsigned len;
      int unsigned nbytes;
      pick = $urandom_range(99);
      if (pick < 4) begin
         send_byte(8'($urandom_range(255)));
         return;
      end
      if (pick < 12)
         len = $urandom_range(131071, 65536);
      else if (pick < 18)
         len = $urandom_range(65535, 256);
      else if (pick < 26)
         len = $urandom_range(130, 120);
      else
         len = $urandom_range(12, 0);
      send_begin(4'($urandom_range(15)), len[16:0], $urandom);
      if (len > 65535) begin
         nbytes = $urandom_range(2, 0);
      end else if (len > 255) begin
         // cut short; the next begin drops it
         nbytes = $urandom_range(8, 1);
      end else begin
         nbytes = len;
         pick   = $urandom_range(99);
         if (pick < 10 && len > 0)
            nbytes = $urandom_range(len - 1, 0);
         else if (pick >= 92)
            nbytes = len + 1;
      end
      for (int i = 0; i < nbytes && items_sent < phase_end; i++)
         send_byte(8'($urandom_range(255)));
   endtask

   task automatic run_phase(input int send_pct, input int stall_pct, input bit link_drop,
                            input bit squeeze);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      phase_end     = items_sent + PHASE_ITEMS;
      if (link_drop) begin
         // take the link down for a few frames; an open frame keeps masking
         write_link(1'b0);
         repeat (6) send_random_frame();
         wait_drained();
         write_link(1'b1);
      end
      // long receiver hold-off while items keep coming
      if (squeeze)
         holds_asked++;
      while (items_sent < phase_end)
         send_random_frame();
      wait_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      run_phase(0, 0, 1'b0, 1'b1);
      run_phase(51, 0, 1'b1, 1'b0);
      run_phase(0, 51, 1'b0, 1'b0);
      run_phase(18, 18, 1'b1, 1'b0);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d items (%0d begin, %0d payload) over a directed set and four idling phases",
               items_sent, begins_sent, bytes_sent);
      $display("Checked %0d response bytes, with link drops and one long receiver hold-off",
               checked_count);
      if (fail_count == 0 && pending == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
